@@ rtl/core/tadc_pkg.sv @@
// ----------------------------------------------------------------------------
// tadc_pkg
// Shared types and constants of the thermistor temperature converter.
// ----------------------------------------------------------------------------
package tadc_pkg;

  localparam int TABLE_DEPTH   = 64;
  localparam int TBL_AW        = $clog2(TABLE_DEPTH);
  localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
  localparam int RES_FRAC_BITS = 8;
  localparam int DIV_NUM_W     = 58;
  localparam int DIV_DEN_W     = 33;
  localparam int DIV_CNT_W     = $clog2(DIV_NUM_W + 1);

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_CONV = 2'd1,
    OP_BACK = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_LOW  = 2'd1,
    ST_HIGH = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_ADC_BITS = 2'd0,
    REG_BIAS     = 2'd1,
    REG_COUNT    = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CMUL,
    S_CDIV,
    S_SRD,
    S_SCHK,
    S_IMUL,
    S_IDIV,
    S_BMUL,
    S_BDIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic                 busy;
    logic [DIV_NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

@@ rtl/core/tadc_ram.sv @@
// ----------------------------------------------------------------------------
// tadc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tadc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/tadc_div.sv @@
// ----------------------------------------------------------------------------
// tadc_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tadc_div import tadc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_NUM_W-1:0] quo_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;

  assign trial = {rem_r, quo_r[DIV_NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.num;
      rem_r <= '0;
      den_r <= req.den;
    end else if (busy_r) begin
      if (!diff[DIV_DEN_W]) begin
        rem_r <= diff[DIV_DEN_W-1:0];
        quo_r <= {quo_r[DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[DIV_DEN_W-1:0];
        quo_r <= {quo_r[DIV_NUM_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.busy = busy_r;
  assign rsp.quo  = quo_r;

endmodule

@@ rtl/core/thermistor_adc_temperature_converter_unit.sv @@
// ----------------------------------------------------------------------------
// thermistor_adc_temperature_converter_unit
// Table-driven thermistor linearizer: ADC count to temperature and back.
// ----------------------------------------------------------------------------
// One item is handled at a time and in_tready is low while it is in work.
// A table load, a no-op or an out-of-range sample goes straight to the result
// stage. A convert runs the resistance division (a multiply state and 58
// divider steps), reads and checks each table entry examined, then runs the
// interpolation division and the result stage; a backconvert reads and checks
// each entry examined, then runs two divisions. The cost is set by the single
// shared bit-serial divider (58 quotient bits) and by the one-read-port table
// RAM, which is scanned one entry at a time, with a read and a check state.
// The result sits in an output register, so a new item may be transferred
// while the previous result still waits on out_tready.
module thermistor_adc_temperature_converter_unit import tadc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata, low bit up: entry_index[5:0], entry_resistance[37:6],
  // entry_temperature[53:38], sample[69:54], temperature_in[93:70], pad.
  input  logic [95:0] in_tdata,
  // tuser: operation[1:0].
  input  logic [1:0]  in_tuser,
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata, low bit up: temperature_out[23:0], adc_out[39:24].
  output logic [39:0] out_tdata,
  // tuser: status[1:0].
  output logic [1:0]  out_tuser,
  // Configuration.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  state_t state_r, state_nxt;

  logic [4:0]       adc_bits_r;
  logic [31:0]      bias_r;
  logic [6:0]       count_r;

  op_t              op_r;
  logic [15:0]      adc_r;
  logic [23:0]      tin_r;
  logic [31:0]      r_r;
  logic [CNT_W-1:0] i_r;
  logic [31:0]      prev_res_r;
  logic [15:0]      prev_temp_r;
  logic [31:0]      cur_res_r;
  logic [15:0]      cur_temp_r;
  logic             neg_r;
  status_t          res_status_r;
  logic [23:0]      res_temp_r;
  logic [15:0]      res_adc_r;
  logic             out_valid_r;
  logic [1:0]       out_status_r;
  logic [23:0]      out_temp_r;
  logic [15:0]      out_adc_r;

  logic             in_xfer;
  logic             out_free;
  logic [4:0]       bits_clamped;
  logic [16:0]      fs_wide;
  logic [15:0]      fs;
  logic [CNT_W-1:0] n_valid;
  logic [47:0]      ram_wdata;
  logic [47:0]      ram_rdata;
  logic             ram_we;
  logic [31:0]      rd_res;
  logic [15:0]      rd_temp;
  logic             hit;
  logic [31:0]      mul_a;
  logic [31:0]      mul_b;
  logic [63:0]      prod;
  logic [23:0]      at24;
  logic [23:0]      bt24;
  logic [24:0]      dt;
  logic [24:0]      dt_neg;
  logic [32:0]      dr;
  logic [32:0]      dr_neg;
  logic [24:0]      tb;
  logic [32:0]      bden;
  logic             mul_neg;
  logic [32:0]      div_den;
  logic [57:0]      sq;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adc_bits_r <= 5'd16;
      bias_r     <= 32'd11315;
      count_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ADC_BITS: adc_bits_r <= cfg_wdata[4:0];
        REG_BIAS:     bias_r     <= cfg_wdata;
        REG_COUNT:    count_r    <= cfg_wdata[6:0];
        default:      ;
      endcase
    end
  end

  assign bits_clamped = (adc_bits_r < 5'd8) ? 5'd8 : ((adc_bits_r > 5'd16) ? 5'd16 : adc_bits_r);
  assign fs_wide      = (17'd1 << bits_clamped) - 17'd1;
  assign fs           = fs_wide[15:0];
  assign n_valid      = (count_r > 7'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : CNT_W'(count_r);

  // Table store: resistance in the upper bits, temperature below.
  assign ram_we    = in_xfer && (op_t'(in_tuser) == OP_LOAD)
                     && ({2'b0, in_tdata[5:0]} < 8'(TABLE_DEPTH));
  assign ram_wdata = {in_tdata[37:6], in_tdata[53:38]};

  tadc_ram #(.WIDTH(48), .DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (TBL_AW'(in_tdata[5:0])),
    .wdata (ram_wdata),
    .raddr (i_r[TBL_AW-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_res  = ram_rdata[47:16];
  assign rd_temp = ram_rdata[15:0];

  always_comb begin
    if (op_r == OP_CONV) begin
      hit = rd_res < r_r;
    end else begin
      hit = $signed({rd_temp, 8'h00}) > $signed(tin_r);
    end
  end

  // Operand selection for the shared multiplier and divider.
  assign at24   = {cur_temp_r, 8'h00};
  assign bt24   = {prev_temp_r, 8'h00};
  assign dt     = {at24[23], at24} - {bt24[23], bt24};
  assign dt_neg = -dt;
  assign dr     = {1'b0, cur_res_r} - {1'b0, prev_res_r};
  assign dr_neg = -dr;
  assign tb     = {tin_r[23], tin_r} - {bt24[23], bt24};
  assign bden   = {1'b0, bias_r} + {1'b0, r_r};

  always_comb begin
    mul_a   = bias_r;
    mul_b   = {16'h0000, adc_r};
    mul_neg = 1'b0;
    div_den = {17'h00000, fs - adc_r};
    unique case (state_r)
      S_CMUL: begin
        mul_a   = bias_r;
        mul_b   = {16'h0000, adc_r};
        div_den = {17'h00000, fs - adc_r};
      end
      S_IMUL: begin
        if (op_r == OP_CONV) begin
          mul_a   = dt[24] ? {7'h00, dt_neg} : {7'h00, dt};
          mul_b   = prev_res_r - r_r;
          mul_neg = dt[24];
          div_den = {1'b0, prev_res_r - cur_res_r};
        end else begin
          mul_a   = dr[32] ? dr_neg[31:0] : dr[31:0];
          mul_b   = {7'h00, tb};
          mul_neg = dr[32];
          div_den = {8'h00, dt};
        end
      end
      S_BMUL: begin
        mul_a   = r_r;
        mul_b   = {16'h0000, fs};
        div_den = bden;
      end
      default: ;
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign div_req = '{start: (state_r == S_CMUL) || (state_r == S_IMUL)
                            || ((state_r == S_BMUL) && (bden != '0)),
                     num:   prod[57:0],
                     den:   div_den};

  tadc_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign sq = neg_r ? (~div_rsp.quo + 58'd1) : div_rsp.quo;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          unique case (op_t'(in_tuser))
            OP_CONV: begin
              if ((in_tdata[69:54] >= fs) || (in_tdata[69:54] == 16'h0000)) begin
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_CMUL;
              end
            end
            OP_BACK: state_nxt = S_SRD;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_CMUL:  state_nxt = S_CDIV;
      S_CDIV:  if (div_rsp.done) state_nxt = S_SRD;
      S_SRD:   state_nxt = (i_r == n_valid) ? S_DONE : S_SCHK;
      S_SCHK: begin
        if (!hit) begin
          state_nxt = S_SRD;
        end else if (i_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_IMUL;
        end
      end
      S_IMUL:  state_nxt = S_IDIV;
      S_IDIV: begin
        if (div_rsp.done) begin
          state_nxt = (op_r == OP_CONV) ? S_DONE : S_BMUL;
        end
      end
      S_BMUL:  state_nxt = (bden == '0) ? S_DONE : S_BDIV;
      S_BDIV:  if (div_rsp.done) state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_tready = (state_r == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          op_r         <= op_t'(in_tuser);
          adc_r        <= in_tdata[69:54];
          tin_r        <= in_tdata[93:70];
          i_r          <= '0;
          res_status_r <= ST_OK;
          res_temp_r   <= '0;
          res_adc_r    <= '0;
          if (op_t'(in_tuser) == OP_CONV) begin
            if (in_tdata[69:54] >= fs) begin
              res_status_r <= ST_LOW;
            end else if (in_tdata[69:54] == 16'h0000) begin
              res_status_r <= ST_HIGH;
            end
          end
        end
      end
      S_CDIV: begin
        if (div_rsp.done) begin
          r_r <= (div_rsp.quo[57:32] != '0) ? 32'hFFFF_FFFF : div_rsp.quo[31:0];
        end
      end
      S_SRD: begin
        if (i_r == n_valid) begin
          if (op_r == OP_CONV) begin
            res_status_r <= ST_HIGH;
          end else begin
            res_adc_r <= fs;
          end
        end
      end
      S_SCHK: begin
        if (!hit) begin
          prev_res_r  <= rd_res;
          prev_temp_r <= rd_temp;
          i_r         <= i_r + 1'b1;
        end else begin
          cur_res_r  <= rd_res;
          cur_temp_r <= rd_temp;
          if ((i_r == '0) && (op_r == OP_CONV)) begin
            res_status_r <= ST_LOW;
          end
        end
      end
      S_IMUL: neg_r <= mul_neg;
      S_IDIV: begin
        if (div_rsp.done) begin
          if (op_r == OP_CONV) begin
            res_temp_r <= bt24 + sq[23:0];
          end else begin
            r_r <= prev_res_r + sq[31:0];
          end
        end
      end
      S_BDIV: if (div_rsp.done) res_adc_r <= div_rsp.quo[15:0];
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && out_free) begin
      out_status_r <= res_status_r;
      out_temp_r   <= res_temp_r;
      out_adc_r    <= res_adc_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {out_adc_r, out_temp_r};

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready)
    else $error("input accepted again while an item is in work");

  a_temp_zero_unless_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != ST_OK)) |-> (out_tdata[23:0] == '0))
    else $error("temperature nonzero on a failed convert");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_search_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCHK) |-> (i_r < n_valid))
    else $error("table search read past the valid entries");
`endif

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the thermistor temperature converter. It fills the lookup
// table, then sends loads, converts and backconverts under several settings.
// A built-in temperature predictor works out each result, and every result
// transfer is compared field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module tb_top;
  import tadc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    status_t     status;
    logic [23:0] temp_out;
    logic [15:0] adc_out;
  } conv_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;

  // Predictor copy of the table and the registers.
  logic [31:0]        lut_res [TABLE_DEPTH];
  logic signed [15:0] lut_temp [TABLE_DEPTH];
  logic [4:0]         res_bits;
  logic [31:0]        bias_kohm;
  logic [6:0]         lut_count;

  conv_result_t pending_results [$];
  int  mismatches;
  int  results_seen;
  int  items_sent;
  int  status_seen [3];
  int  cycles;
  int  sender_gap_max;
  int  receiver_stall_max;
  int  holdoff_cycles;

  thermistor_adc_temperature_converter_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles,
               pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic longint unsigned scale_max();
    int b;
    b = res_bits;
    if (b < 8) b = 8;
    if (b > 16) b = 16;
    return (longint'(1) << b) - 1;
  endfunction

  function automatic int live_entries();
    return (lut_count > TABLE_DEPTH) ? TABLE_DEPTH : lut_count;
  endfunction

  // Works out the result of one item and applies its table write.
  function automatic conv_result_t predict_temperature(op_t op, logic [5:0] idx,
      logic [31:0] res, logic [15:0] tmp, logic [15:0] adc, logic [23:0] tin);
    conv_result_t r;
    longint unsigned fs, rr, ur, den;
    longint br, ar, bt, at, t, rs;
    int n, i;
    r = '0;
    r.status = ST_OK;
    fs = scale_max();
    n = live_entries();
    case (op)
      OP_LOAD: begin
        lut_res[idx]  = res;
        lut_temp[idx] = tmp;
      end
      OP_CONV: begin
        if (adc >= fs) begin
          r.status = ST_LOW;
        end else if (adc == 0) begin
          r.status = ST_HIGH;
        end else begin
          rr = (longint'(bias_kohm) * adc) / (fs - adc);
          if (rr > 64'hFFFF_FFFF) rr = 64'hFFFF_FFFF;
          for (i = 0; i < n; i++)
            if (longint'(lut_res[i]) < rr) break;
          if (i == n) begin
            r.status = ST_HIGH;
          end else if (i == 0) begin
            r.status = ST_LOW;
          end else begin
            rs = longint'(rr);
            br = longint'(lut_res[i-1]);
            ar = longint'(lut_res[i]);
            bt = longint'(lut_temp[i-1]) * 256;
            at = longint'(lut_temp[i]) * 256;
            t  = bt + ((at - bt) * (br - rs)) / (br - ar);
            r.temp_out = t[23:0];
          end
        end
      end
      OP_BACK: begin
        t = longint'($signed(tin));
        for (i = 0; i < n; i++)
          if (longint'(lut_temp[i]) * 256 > t) break;
        if (i == n) begin
          r.adc_out = fs[15:0];
        end else if (i > 0) begin
          br = longint'(lut_res[i-1]);
          ar = longint'(lut_res[i]);
          bt = longint'(lut_temp[i-1]) * 256;
          at = longint'(lut_temp[i]) * 256;
          rs = br + ((ar - br) * (t - bt)) / (at - bt);
          ur = longint'(rs);
          den = longint'(bias_kohm) + ur;
          if (den != 0) begin
            rr = (ur * fs) / den;
            r.adc_out = rr[15:0];
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Result checker: compares every result transfer with the oldest expectation.
  always @(posedge clk) begin
    conv_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result status=%0d data=%h", out_tuser, out_tdata);
      end else begin
        want = pending_results.pop_front();
        if (want.status <= ST_HIGH) status_seen[want.status]++;
        if (out_tuser != want.status || out_tdata[23:0] != want.temp_out ||
            out_tdata[39:24] != want.adc_out) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status=%0d temp=%h adc=%h, got status=%0d temp=%h adc=%h",
                     want.status, want.temp_out, want.adc_out,
                     out_tuser, out_tdata[23:0], out_tdata[39:24]);
        end
      end
    end
  end

  // Receiver: random stalls per result, plus a long hold-off when asked.
  initial begin
    int stall;
    stall = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) stall = $urandom_range(0, receiver_stall_max);
      if (holdoff_cycles > 0) begin
        holdoff_cycles--;
        out_tready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(op_t op, logic [5:0] idx, logic [31:0] res,
      logic [15:0] tmp, logic [15:0] adc, logic [23:0] tin);
    int gap;
    gap = $urandom_range(0, sender_gap_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, tin, adc, tmp, res, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(predict_temperature(op, idx, res, tmp, adc, tin));
    items_sent++;
  endtask

  // Drops the input and waits until every expected result has come.
  task automatic drain();
    in_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ADC_BITS: res_bits  = value[4:0];
      REG_BIAS:     bias_kohm = value;
      REG_COUNT:    lut_count = value[6:0];
      default: ;
    endcase
  endtask

  task automatic convert(logic [15:0] adc);
    send_item(OP_CONV, $urandom, $urandom, $urandom, adc, $urandom);
  endtask

  task automatic backconvert(logic [23:0] tin);
    send_item(OP_BACK, $urandom, $urandom, $urandom, $urandom, tin);
  endtask

  // Loads a descending-resistance, ascending-temperature table around the bias.
  task automatic load_monotone_table(int entries);
    logic [31:0] res;
    logic signed [15:0] tmp;
    int i;
    res = 32'($urandom_range(4, 64)) * (bias_kohm > 32'h0100_0000 ? 32'h0100_0000 : bias_kohm);
    tmp = 16'($signed($urandom_range(0, 200)) - 100);
    for (i = 0; i < entries; i++) begin
      send_item(OP_LOAD, 6'(i), res, tmp, $urandom, $urandom);
      res = res - res / $urandom_range(4, 12) - $urandom_range(0, 3);
      tmp = tmp + 16'($urandom_range(1, 15));
    end
  endtask

  task automatic test_directed();
    // Empty table at reset: both ends reached at once.
    convert(16'd1000);
    backconvert(24'd0);
    load_monotone_table(TABLE_DEPTH);
    // Extreme field values at the last two entries, kept out of the active count.
    send_item(OP_LOAD, 6'd63, 32'hFFFF_FFFF, 16'sh8000, 16'hFFFF, 24'hFF_FFFF);
    send_item(OP_LOAD, 6'd62, 32'h0000_0000, 16'sh7FFF, 16'h0000, 24'h00_0000);
    send_item(OP_NONE, 6'h3F, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 24'hFF_FFFF);
    drain();
    write_reg(REG_COUNT, 7'd62);
    convert(16'd0);
    convert(16'hFFFF);
    convert(16'hFFFE);
    convert(16'd1);
    convert(16'd32768);
    convert(16'd60000);
    backconvert(24'h80_0000);
    backconvert(24'h7F_FFFF);
    backconvert(24'(longint'(lut_temp[10]) * 256 + 77));
    backconvert(24'(longint'(lut_temp[0]) * 256));
    drain();
    // Full count reaches the extreme entries.
    write_reg(REG_COUNT, 7'd127);
    convert(16'd30000);
    backconvert(24'h00_1234);
    backconvert(24'h7F_FFFF);
    drain();
  endtask

  task automatic test_config_sweep();
    logic [31:0] bias_set [4];
    logic [4:0]  bits_set [5];
    int b, k;
    bias_set = '{32'd1, 32'hFFFF_FFFF, 32'd11315, 32'd500};
    bits_set = '{5'd0, 5'd8, 5'd12, 5'd16, 5'd31};
    for (b = 0; b < 4; b++) begin
      for (k = 0; k < 5; k++) begin
        write_reg(REG_ADC_BITS, bits_set[k]);
        write_reg(REG_BIAS, bias_set[b]);
        write_reg(REG_COUNT, (k == 0) ? 7'd0 : (k == 1) ? 7'd1 : (k == 2) ? 7'd2 : 7'd64);
        convert(16'($urandom_range(0, int'(scale_max()))));
        convert(16'(scale_max() - 1));
        backconvert(24'(longint'(lut_temp[$urandom_range(0, 30)]) * 256
                        + $urandom_range(0, 255)));
        drain();
      end
    end
  endtask

  // Long receiver hold-off while the sender keeps offering work.
  task automatic test_backpressure();
    sender_gap_max = 0;
    holdoff_cycles = 2000;
    repeat (12) convert(16'($urandom_range(1, int'(scale_max()) - 1)));
    drain();
    sender_gap_max = 10;
  endtask

  task automatic test_random(int phases);
    int p, j, pick, fs, lo, hi;
    for (p = 0; p < phases; p++) begin
      sender_gap_max     = (p % 4 == 3) ? 0 : 10;
      receiver_stall_max = (p % 4 == 3) ? 0 : 10;
      write_reg(REG_ADC_BITS, (p % 5 == 0) ? 5'($urandom) : 5'($urandom_range(8, 16)));
      write_reg(REG_BIAS, (p % 7 == 0) ? $urandom : $urandom_range(200, 100000));
      write_reg(REG_COUNT, (p % 6 == 0) ? 7'($urandom) : 7'($urandom_range(2, 64)));
      if (p % 3 == 0) load_monotone_table(TABLE_DEPTH);
      fs = int'(scale_max());
      lo = int'(lut_temp[0]) * 256 - 512;
      hi = int'(lut_temp[live_entries() > 0 ? live_entries() - 1 : 0]) * 256 + 512;
      if (hi < lo) hi = lo;
      for (j = 0; j < 50; j++) begin
        pick = $urandom_range(0, 99);
        if (pick < 8)
          send_item(OP_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom);
        else if (pick < 11)
          send_item(OP_NONE, $urandom, $urandom, $urandom, $urandom, $urandom);
        else if (pick < 48)
          convert(16'($urandom_range(0, fs)));
        else if (pick < 52)
          convert(16'($urandom));
        else if (pick < 92)
          backconvert(24'(lo + int'($urandom_range(0, hi - lo))));
        else
          backconvert(24'($urandom));
      end
      drain();
    end
  endtask

  initial begin
    rst_n              <= 1'b0;
    in_tvalid          <= 1'b0;
    in_tdata           <= '0;
    in_tuser           <= OP_LOAD;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_ADC_BITS;
    cfg_wdata          <= '0;
    mismatches         = 0;
    results_seen       = 0;
    items_sent         = 0;
    status_seen        = '{0, 0, 0};
    cycles             = 0;
    sender_gap_max     = 10;
    receiver_stall_max = 10;
    holdoff_cycles     = 0;
    res_bits           = 5'd16;
    bias_kohm          = 32'd11315;
    lut_count          = 7'd0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_config_sweep();
    test_backpressure();
    test_random(9);
    drain();

    $display("sent %0d items, checked %0d results (ok %0d, low %0d, high %0d)",
             items_sent, results_seen, status_seen[0], status_seen[1], status_seen[2]);
    $display("covered table loads, converts and backconverts over %0d settings phases",
             9 + 20);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
